/* rtl/core/bil_pkg.sv */
// Shared types and constants for the bounded integer list engine.
// No dependencies; used by bil_ctrl, bil_dp and the top level.
package bil_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 5;
    localparam int IN_TD_W  = 40;
    localparam int OUT_TD_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_CLEAR      = 3'd6
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath strobes
    typedef struct packed {
        logic load;   // capture the accepted command
        logic exec;   // update the list
        logic post;   // load the result register
    } t_dp_cmd;

endpackage

/* rtl/core/bil_ctrl.sv */
// Sequencer for the bounded integer list engine: accept, execute, post result.
// Depends on bil_pkg.
module bil_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output bil_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POST
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_post;

    assign w_accept   = (r_state == S_IDLE) && i_s_tvalid;
    assign w_post     = (r_state == S_POST) && (!r_out_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.post = w_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_POST;
                end
                S_POST: begin
                    // wait here while the previous result is still unread
                    if (w_post) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_post)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted beat did not start execution");

    a_exec_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_POST)
        else $error("execute did not advance to post");

    a_post_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_post |=> r_out_valid && r_state == S_IDLE)
        else $error("posted result not presented");

endmodule

/* rtl/core/bil_dp.sv */
// Datapath for the bounded integer list engine: a row of compare-and-shift
// cells, the element count and the result register. Depends on bil_pkg.
module bil_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bil_pkg::t_dp_cmd               i_cmd,
    input  logic [bil_pkg::OP_W-1:0]       i_opcode,
    input  logic signed [bil_pkg::VAL_W-1:0] i_operand_value,
    output logic [bil_pkg::ST_W-1:0]       o_status,
    output logic                           o_found,
    output logic signed [bil_pkg::VAL_W-1:0] o_front_value,
    output logic signed [bil_pkg::VAL_W-1:0] o_back_value,
    output logic [bil_pkg::OCNT_W-1:0]     o_element_count,
    output logic                           o_is_empty
);

    logic [bil_pkg::VAL_W-1:0] r_cell [bil_pkg::DEPTH];
    logic [bil_pkg::VAL_W-1:0] n_cell [bil_pkg::DEPTH];
    logic [bil_pkg::CNT_W-1:0] r_count;
    logic [bil_pkg::CNT_W-1:0] n_count;

    bil_pkg::t_opcode          r_op;
    logic [bil_pkg::VAL_W-1:0] r_val;
    bil_pkg::t_status          r_status;
    bil_pkg::t_status          n_status;
    logic                      r_found;
    logic                      n_found;

    logic [bil_pkg::DEPTH-1:0] w_hit;
    logic [bil_pkg::DEPTH-1:0] w_shift;
    logic                      w_full;
    logic                      w_empty;
    logic [bil_pkg::IDX_W-1:0] w_back_idx;
    logic [bil_pkg::CNT_W-1:0] w_back_cnt;

    logic [bil_pkg::ST_W-1:0]   r_o_status;
    logic                       r_o_found;
    logic [bil_pkg::VAL_W-1:0]  r_o_front;
    logic [bil_pkg::VAL_W-1:0]  r_o_back;
    logic [bil_pkg::OCNT_W-1:0] r_o_count;
    logic                       r_o_empty;

    assign w_full  = (r_count >= bil_pkg::CNT_W'(bil_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    // per-cell match, masked to live entries; w_shift marks cells at or
    // after the first match
    always_comb begin
        for (int i = 0; i < bil_pkg::DEPTH; i++)
            w_hit[i] = (r_cell[i] == r_val) && (bil_pkg::CNT_W'(i) < r_count);
        w_shift[0] = w_hit[0];
        for (int i = 1; i < bil_pkg::DEPTH; i++)
            w_shift[i] = w_shift[i-1] | w_hit[i];
    end

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_status = bil_pkg::ST_OK;
        n_found  = 1'b0;
        case (r_op)
            bil_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = bil_pkg::ST_FULL;
                end else begin
                    n_cell[0] = r_val;
                    for (int i = 1; i < bil_pkg::DEPTH; i++)
                        n_cell[i] = r_cell[i-1];
                    n_count = r_count + 1'b1;
                end
            end
            bil_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = bil_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < bil_pkg::DEPTH; i++)
                        if (r_count[bil_pkg::IDX_W-1:0] == bil_pkg::IDX_W'(i))
                            n_cell[i] = r_val;
                    n_count = r_count + 1'b1;
                end
            end
            bil_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = bil_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < bil_pkg::DEPTH - 1; i++)
                        n_cell[i] = r_cell[i+1];
                    n_count = r_count - 1'b1;
                end
            end
            bil_pkg::OP_POP_BACK: begin
                if (w_empty) n_status = bil_pkg::ST_EMPTY;
                else         n_count  = r_count - 1'b1;
            end
            bil_pkg::OP_SEARCH: begin
                n_found = |w_hit;
            end
            bil_pkg::OP_ERASE: begin
                n_found = |w_hit;
                for (int i = 0; i < bil_pkg::DEPTH - 1; i++)
                    if (w_shift[i]) n_cell[i] = r_cell[i+1];
                if (|w_hit) n_count = r_count - 1'b1;
            end
            bil_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_back_cnt = r_count - 1'b1;
    assign w_back_idx = w_back_cnt[bil_pkg::IDX_W-1:0];

    function automatic logic [bil_pkg::OCNT_W-1:0] OCNT_FIT(
        input logic [bil_pkg::CNT_W-1:0] c
    );
        logic [bil_pkg::CNT_W+bil_pkg::OCNT_W-1:0] wide;
        wide     = '0;
        wide[bil_pkg::CNT_W-1:0] = c;
        OCNT_FIT = wide[bil_pkg::OCNT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= bil_pkg::t_opcode'(i_opcode);
            r_val <= i_operand_value;
        end
        if (i_cmd.exec) begin
            r_cell   <= n_cell;
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (i_cmd.post) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_front  <= w_empty ? '0 : r_cell[0];
            r_o_back   <= w_empty ? '0 : r_cell[w_back_idx];
            r_o_count  <= OCNT_FIT(r_count);
            r_o_empty  <= w_empty;
        end
    end

    assign o_status        = r_o_status;
    assign o_found         = r_o_found;
    assign o_front_value   = r_o_front;
    assign o_back_value    = r_o_back;
    assign o_element_count = r_o_count;
    assign o_is_empty      = r_o_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bil_pkg::CNT_W'(bil_pkg::DEPTH))
        else $error("element count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == bil_pkg::OP_PUSH_BACK && !w_full)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow the list");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == bil_pkg::OP_CLEAR) |=> r_count == '0)
        else $error("clear left entries");

endmodule

/* rtl/core/bounded_int_list_engine_unit.sv */
// Bounded integer list engine: deque of up to DEPTH signed words with search
// and erase of the first match. Each command steps through accept, cell-row update and
// result load, and the next command is taken only after that result load; the result
// register lets the next beat enter while a result waits.
// Reset (synchronous, active low) empties the list; stored words are not cleared.
// Depends on bil_pkg, bil_ctrl and bil_dp.
module bounded_int_list_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bil_pkg::IN_TD_W-1:0]  s_tdata,  // opcode[2:0], operand_value[34:3]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bil_pkg::OUT_TD_W-1:0] m_tdata   // status[1:0], found[2],
                                                   // front_value[34:3], back_value[66:35],
                                                   // element_count[71:67], is_empty[72]
);

    bil_pkg::t_dp_cmd                  w_cmd;
    logic [bil_pkg::ST_W-1:0]          w_status;
    logic                              w_found;
    logic signed [bil_pkg::VAL_W-1:0]  w_front;
    logic signed [bil_pkg::VAL_W-1:0]  w_back;
    logic [bil_pkg::OCNT_W-1:0]        w_count;
    logic                              w_empty;

    bil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (w_cmd)
    );

    bil_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (s_tdata[2:0]),
        .i_operand_value (s_tdata[34:3]),
        .o_status        (w_status),
        .o_found         (w_found),
        .o_front_value   (w_front),
        .o_back_value    (w_back),
        .o_element_count (w_count),
        .o_is_empty      (w_empty)
    );

    assign m_tdata = {7'd0, w_empty, w_count, w_back, w_front, w_found, w_status};

endmodule

/* tb/sv/bounded_int_list_engine_unit_tb.sv */
// Self-checking bench for bounded_int_list_engine_unit: drives deque commands on the
// input stream and checks every result beat against a behavioral copy of the list.
// Depends on bil_pkg and the engine RTL only.
module bounded_int_list_engine_unit_tb;

    localparam logic [bil_pkg::OP_W-1:0] OP_UNUSED      = 3'd7;
    localparam int                       WATCHDOG_LIMIT = 2000;
    localparam int                       DRAIN_CYCLES   = 12;

    // same layout as m_tdata[72:0], lowest field last
    typedef struct packed {
        logic                       empty;
        logic [bil_pkg::OCNT_W-1:0] count;
        logic [bil_pkg::VAL_W-1:0]  back;
        logic [bil_pkg::VAL_W-1:0]  front;
        logic                       found;
        logic [bil_pkg::ST_W-1:0]   status;
    } t_list_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bil_pkg::IN_TD_W-1:0]  s_tdata;   // opcode[2:0], operand_value[34:3]
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bil_pkg::OUT_TD_W-1:0] m_tdata;   // status[1:0], found[2], front_value[34:3],
                                             // back_value[66:35], element_count[71:67],
                                             // is_empty[72]

    // behavioral copy of the list
    logic [bil_pkg::VAL_W-1:0] list_words [bil_pkg::DEPTH];
    int                        list_len;
    t_list_result              pending_results [$];
    logic [bil_pkg::VAL_W-1:0] value_pool [8];

    int  mismatch_count;
    int  idle_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  rx_hold;

    bounded_int_list_engine_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void drop_word(int idx);
        int k;
        for (k = idx; k < list_len - 1; k++)
            list_words[k] = list_words[k + 1];
        list_len--;
    endfunction

    // update the list for one accepted command and queue the result it causes
    function automatic void apply_list_cmd(logic [bil_pkg::OP_W-1:0] op,
                                           logic [bil_pkg::VAL_W-1:0] val);
        t_list_result r;
        int           k;
        int           hit;
        r        = '0;
        r.status = bil_pkg::ST_OK;
        hit      = -1;
        case (op)
            bil_pkg::OP_PUSH_FRONT: begin
                if (list_len >= bil_pkg::DEPTH) begin
                    r.status = bil_pkg::ST_FULL;
                end else begin
                    for (k = list_len; k > 0; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[0] = val;
                    list_len++;
                end
            end
            bil_pkg::OP_PUSH_BACK: begin
                if (list_len >= bil_pkg::DEPTH) begin
                    r.status = bil_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            bil_pkg::OP_POP_FRONT: begin
                if (list_len == 0) r.status = bil_pkg::ST_EMPTY;
                else drop_word(0);
            end
            bil_pkg::OP_POP_BACK: begin
                if (list_len == 0) r.status = bil_pkg::ST_EMPTY;
                else list_len--;
            end
            bil_pkg::OP_SEARCH, bil_pkg::OP_ERASE: begin
                for (k = 0; k < list_len; k++)
                    if (hit < 0 && list_words[k] == val) hit = k;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    if (op == bil_pkg::OP_ERASE) drop_word(hit);
                end
            end
            bil_pkg::OP_CLEAR: list_len = 0;
            default: ;
        endcase
        if (list_len > 0) begin
            r.front = list_words[0];
            r.back  = list_words[list_len - 1];
        end
        r.count = list_len[bil_pkg::OCNT_W-1:0];
        r.empty = (list_len == 0);
        pending_results = {pending_results, r};
    endfunction

    // one command beat; optional idle gap before it
    task automatic send_cmd(input logic [bil_pkg::OP_W-1:0] op,
                            input logic [bil_pkg::VAL_W-1:0] val);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bil_pkg::IN_TD_W - bil_pkg::VAL_W - bil_pkg::OP_W){1'b0}}, val, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        apply_list_cmd(op, val);
    endtask

    function automatic logic [bil_pkg::VAL_W-1:0] pick_operand(
        logic [bil_pkg::OP_W-1:0] op
    );
        if ((op == bil_pkg::OP_SEARCH || op == bil_pkg::OP_ERASE) && list_len > 0 &&
            $urandom_range(0, 9) < 6)
            return list_words[$urandom_range(0, list_len - 1)];
        if ($urandom_range(0, 9) < 4)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // push/pop mix leans toward keeping the list partly filled
    function automatic logic [bil_pkg::OP_W-1:0] pick_opcode();
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        if (r < 2)  return bil_pkg::OP_CLEAR;
        if (r < 4)  return OP_UNUSED;
        if (r < 16) return bil_pkg::OP_SEARCH;
        if (r < 28) return bil_pkg::OP_ERASE;
        push_pct = (list_len <= 3) ? 70 : (list_len >= bil_pkg::DEPTH - 2) ? 35 : 52;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? bil_pkg::OP_PUSH_FRONT : bil_pkg::OP_PUSH_BACK;
        return $urandom_range(0, 1) ? bil_pkg::OP_POP_FRONT : bil_pkg::OP_POP_BACK;
    endfunction

    task automatic check_field(input string name, input logic [bil_pkg::VAL_W-1:0] exp_v,
                               input logic [bil_pkg::VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[$bits(t_list_result)-1:0];
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding: %0h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("status",        want.status, got.status);
                check_field("found",         want.found,  got.found);
                check_field("front_value",   want.front,  got.front);
                check_field("back_value",    want.back,   got.back);
                check_field("element_count", want.count,  got.count);
                check_field("is_empty",      want.empty,  got.empty);
            end
        end
    end

    // downstream back-pressure in random bursts
    initial begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                rx_hold = $urandom_range(0, 18);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic test_empty_list();
        send_cmd(bil_pkg::OP_POP_FRONT, $urandom);
        send_cmd(bil_pkg::OP_POP_BACK, $urandom);
        send_cmd(bil_pkg::OP_SEARCH, 32'h0);
        send_cmd(bil_pkg::OP_ERASE, 32'h0);
    endtask

    task automatic test_directed_ops();
        send_cmd(bil_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_cmd(bil_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_cmd(bil_pkg::OP_PUSH_FRONT, 32'h0);
        send_cmd(bil_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_cmd(bil_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_cmd(bil_pkg::OP_SEARCH, 32'h1234_5678);
        send_cmd(bil_pkg::OP_ERASE, 32'h1234_5678);      // absent: list untouched
        send_cmd(bil_pkg::OP_PUSH_BACK, 32'h8000_0000);  // duplicate, erase must take the first
        send_cmd(bil_pkg::OP_ERASE, 32'h8000_0000);
        send_cmd(OP_UNUSED, 32'hFFFF_FFFF);
        send_cmd(bil_pkg::OP_POP_FRONT, $urandom);
        send_cmd(bil_pkg::OP_POP_BACK, $urandom);
        send_cmd(bil_pkg::OP_ERASE, 32'h8000_0000);
        send_cmd(bil_pkg::OP_CLEAR, $urandom);
        send_cmd(bil_pkg::OP_SEARCH, 32'h0);
        send_cmd(bil_pkg::OP_POP_BACK, $urandom);
        send_cmd(bil_pkg::OP_PUSH_BACK, 32'h5555_AAAA);
        send_cmd(bil_pkg::OP_ERASE, 32'h5555_AAAA);      // erase the only element
    endtask

    task automatic test_fill_and_overflow(input int rounds);
        int n;
        for (n = 0; n < rounds; n++) begin
            while (list_len < bil_pkg::DEPTH)
                send_cmd($urandom_range(0, 1) ? bil_pkg::OP_PUSH_FRONT : bil_pkg::OP_PUSH_BACK,
                         pick_operand(bil_pkg::OP_PUSH_BACK));
            send_cmd(bil_pkg::OP_PUSH_FRONT, $urandom);
            send_cmd(bil_pkg::OP_PUSH_BACK, $urandom);
            send_cmd(bil_pkg::OP_SEARCH, list_words[$urandom_range(0, bil_pkg::DEPTH - 1)]);
            send_cmd(bil_pkg::OP_ERASE, list_words[$urandom_range(1, bil_pkg::DEPTH - 2)]);
            send_cmd(bil_pkg::OP_ERASE, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                send_cmd(bil_pkg::OP_CLEAR, $urandom);
            end else begin
                while (list_len > 0)
                    send_cmd($urandom_range(0, 1) ? bil_pkg::OP_POP_FRONT
                                                  : bil_pkg::OP_POP_BACK, $urandom);
            end
            send_cmd($urandom_range(0, 1) ? bil_pkg::OP_POP_FRONT : bil_pkg::OP_POP_BACK,
                     $urandom);
        end
    endtask

    task automatic test_random_ops(input int count);
        logic [bil_pkg::OP_W-1:0] op;
        int                       n;
        for (n = 0; n < count; n++) begin
            op = pick_opcode();
            send_cmd(op, pick_operand(op));
        end
    endtask

    initial begin
        int n;
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        list_len       = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        value_pool[0]  = 32'h8000_0000;
        value_pool[1]  = 32'h7FFF_FFFF;
        value_pool[2]  = 32'h0;
        value_pool[3]  = 32'hFFFF_FFFF;
        for (n = 4; n < 8; n++) value_pool[n] = $urandom;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_directed_ops();
        test_fill_and_overflow(6);
        test_random_ops(700);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_fill_and_overflow(1);
        test_random_ops(330);

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* bounded_int_list_engine_unit.f */
rtl/core/bil_pkg.sv
rtl/core/bil_ctrl.sv
rtl/core/bil_dp.sv
rtl/core/bounded_int_list_engine_unit.sv
tb/sv/bounded_int_list_engine_unit_tb.sv
